[hw/rtl/char_lcd_nibble_sequencer_macros.svh]
// Assertion macros used by the checker of this block
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define CLNS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clns assertion failed");

// Next-cycle implication, sampled on clk, off while in reset
`define CLNS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clns assertion failed");

`endif

[hw/rtl/clns_pkg.sv]
package clns_pkg;

    localparam logic [4:0] OP_INIT        = 5'd0;
    localparam logic [4:0] OP_CHAR        = 5'd1;
    localparam logic [4:0] OP_CLEAR       = 5'd2;
    localparam logic [4:0] OP_HOME        = 5'd3;
    localparam logic [4:0] OP_CURSOR_ON   = 5'd4;
    localparam logic [4:0] OP_CURSOR_OFF  = 5'd5;
    localparam logic [4:0] OP_BLINK_ON    = 5'd6;
    localparam logic [4:0] OP_BLINK_OFF   = 5'd7;
    localparam logic [4:0] OP_DISPLAY_ON  = 5'd8;
    localparam logic [4:0] OP_DISPLAY_OFF = 5'd9;
    localparam logic [4:0] OP_BL_ON       = 5'd10;
    localparam logic [4:0] OP_BL_OFF      = 5'd11;
    localparam logic [4:0] OP_SHIFT_DR    = 5'd12;
    localparam logic [4:0] OP_SHIFT_DL    = 5'd13;
    localparam logic [4:0] OP_SHIFT_CR    = 5'd14;
    localparam logic [4:0] OP_SHIFT_CL    = 5'd15;
    localparam logic [4:0] OP_SET_CURSOR  = 5'd16;

    localparam logic CFG_LINE_COUNT  = 1'b0;
    localparam logic CFG_BUS_ADDRESS = 1'b1;

    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_HOME         = 8'h03;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CMD_DISPLAY_CTRL = 8'h08;
    localparam logic [7:0] CMD_SHIFT_DR     = 8'h1C;
    localparam logic [7:0] CMD_SHIFT_DL     = 8'h18;
    localparam logic [7:0] CMD_SHIFT_CR     = 8'h14;
    localparam logic [7:0] CMD_SHIFT_CL     = 8'h10;
    localparam logic [7:0] CMD_FUNC_1LINE   = 8'h24;
    localparam logic [7:0] CMD_FUNC_2LINE   = 8'h28;
    localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;
    localparam logic [7:0] INIT_WAKE        = 8'h30;
    localparam logic [7:0] INIT_4BIT        = 8'h20;

    localparam logic [2:0] DISP_ON     = 3'b100;
    localparam logic [2:0] DISP_CURSOR = 3'b010;
    localparam logic [2:0] DISP_BLINK  = 3'b001;
    localparam logic [2:0] DISP_INIT   = 3'b110;

    localparam logic [6:0] COL_MAX     = 7'd39;
    localparam logic [6:0] LINE2_BASE  = 7'h40;
    localparam logic [1:0] ONE_LINE    = 2'd1;

    localparam logic [15:0] PAUSE_POWER_UP = 16'd50000;
    localparam logic [15:0] PAUSE_INIT     = 16'd10000;
    localparam logic [15:0] PAUSE_EN_HIGH  = 16'd450;
    localparam logic [15:0] PAUSE_EN_LOW   = 16'd400;

    localparam int EN_POS = 2;
    localparam int BL_POS = 3;

    typedef enum logic [1:0] {
        JOB_INIT,
        JOB_VALUE,
        JOB_RAW
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] value;
        logic       rs;
        logic       bl;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LEAD,
        BK_WRITE,
        BK_GAP,
        BK_SINGLE
    } back_state_t;

endpackage

[hw/rtl/clns_ifs.sv]
interface clns_cmd_if;
    logic       valid;
    logic       ready;
    logic [4:0] op;
    logic [7:0] char_code;
    logic [7:0] line_select;
    logic [7:0] column;

    modport source (output valid, op, char_code, line_select, column, input ready);
    modport sink (input valid, op, char_code, line_select, column, output ready);
endinterface

interface clns_item_if;
    logic        valid;
    logic        ready;
    logic        is_pause;
    logic [7:0]  bus_byte;
    logic [15:0] pause_us;
    logic [6:0]  target_address;
    logic        last;

    modport source (output valid, is_pause, bus_byte, pause_us, target_address, last,
                    input ready);
    modport sink (input valid, is_pause, bus_byte, pause_us, target_address, last,
                  output ready);
endinterface

[hw/rtl/clns_front.sv]
module clns_front
    import clns_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    clns_cmd_if.sink      cmd,
    input  logic [1:0]    line_count,
    input  logic          q_full,
    output logic          q_push,
    output job_t          q_job
);

    logic [2:0] display_bits_reg;
    logic [2:0] display_bits_next;
    logic       backlight_reg;
    logic       backlight_next;
    logic       accept;
    logic       known;
    logic       ctrl;
    logic [2:0] dbit;
    logic [6:0] col_clamped;
    logic [6:0] pos;
    logic       line2;

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && !q_full;
    assign q_push    = accept && known;

    assign col_clamped = (cmd.column > {1'b0, COL_MAX}) ? COL_MAX : cmd.column[6:0];
    assign line2       = (line_count != ONE_LINE) && (cmd.line_select >= 8'd2);
    assign pos         = col_clamped + (line2 ? LINE2_BASE : 7'd0);

    always_comb
    begin
        display_bits_next = display_bits_reg;
        backlight_next    = backlight_reg;
        known             = 1'b1;
        ctrl              = 1'b0;
        dbit              = DISP_ON;
        q_job.kind        = JOB_VALUE;
        q_job.value       = 8'd0;
        q_job.rs          = 1'b0;
        q_job.bl          = backlight_reg;
        case (cmd.op)
            OP_INIT:
            begin
                backlight_next    = 1'b1;
                display_bits_next = DISP_INIT;
                q_job.kind        = JOB_INIT;
                q_job.value       = (line_count == ONE_LINE) ? CMD_FUNC_1LINE : CMD_FUNC_2LINE;
                q_job.bl          = 1'b1;
            end
            OP_CHAR:
            begin
                q_job.value = cmd.char_code;
                q_job.rs    = 1'b1;
            end
            OP_CLEAR:    q_job.value = CMD_CLEAR;
            OP_HOME:     q_job.value = CMD_HOME;
            OP_CURSOR_ON, OP_CURSOR_OFF:
            begin
                ctrl = 1'b1;
                dbit = DISP_CURSOR;
            end
            OP_BLINK_ON, OP_BLINK_OFF:
            begin
                ctrl = 1'b1;
                dbit = DISP_BLINK;
            end
            OP_DISPLAY_ON, OP_DISPLAY_OFF:
            begin
                ctrl = 1'b1;
                dbit = DISP_ON;
            end
            OP_BL_ON, OP_BL_OFF:
            begin
                backlight_next = !cmd.op[0];
                q_job.kind     = JOB_RAW;
                q_job.bl       = !cmd.op[0];
            end
            OP_SHIFT_DR: q_job.value = CMD_SHIFT_DR;
            OP_SHIFT_DL: q_job.value = CMD_SHIFT_DL;
            OP_SHIFT_CR: q_job.value = CMD_SHIFT_CR;
            OP_SHIFT_CL: q_job.value = CMD_SHIFT_CL;
            OP_SET_CURSOR: q_job.value = CMD_SET_DDRAM | {1'b0, pos};
            default:     known = 1'b0;
        endcase
        if (ctrl)
        begin
            display_bits_next = cmd.op[0] ? (display_bits_reg & ~dbit)
                                          : (display_bits_reg | dbit);
            q_job.value       = CMD_DISPLAY_CTRL | {5'd0, display_bits_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_bits_reg <= 3'd0;
            backlight_reg    <= 1'b0;
        end
        else if (accept)
        begin
            display_bits_reg <= display_bits_next;
            backlight_reg    <= backlight_next;
        end
    end

endmodule

[hw/rtl/clns_queue.sv]
module clns_queue
    import clns_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/clns_back.sv]
module clns_back
    import clns_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  job_t         q_job,
    output logic         q_pop,
    input  logic [6:0]   bus_address,
    clns_item_if.source  item
);

    localparam logic [1:0] WR_SETUP = 2'd0;
    localparam logic [1:0] WR_PULSE = 2'd1;
    localparam logic [1:0] WR_HOLD  = 2'd2;
    localparam logic [2:0] GRP_LAST = 3'd7;

    back_state_t st_reg;
    back_state_t st_next;
    job_t        job_reg;
    job_t        job_next;
    logic [2:0]  grp_reg;
    logic [2:0]  grp_next;
    logic        nib_reg;
    logic        nib_next;
    logic [1:0]  wr_reg;
    logic [1:0]  wr_next;

    logic        out_valid_reg;
    logic        out_pause_reg;
    logic [7:0]  out_byte_reg;
    logic [15:0] out_us_reg;
    logic [6:0]  out_addr_reg;
    logic        out_last_reg;

    logic        advance;
    logic        emit;
    logic        i_pause;
    logic [7:0]  i_byte;
    logic [15:0] i_us;
    logic        i_last;
    logic [7:0]  val;
    logic [3:0]  nib_bits;
    logic [7:0]  base;
    logic        single_nib;
    logic        final_nib;

    assign advance = !out_valid_reg || item.ready;

    always_comb
    begin
        val = job_reg.value;
        if (job_reg.kind == JOB_INIT)
        begin
            if (!grp_reg[2])
            begin
                val = (grp_reg[1:0] == 2'd3) ? INIT_4BIT : INIT_WAKE;
            end
            else
            begin
                case (grp_reg[1:0])
                    2'd0:    val = job_reg.value;
                    2'd1:    val = CMD_DISPLAY_CTRL | {5'd0, DISP_INIT};
                    2'd2:    val = CMD_CLEAR;
                    default: val = CMD_ENTRY_MODE;
                endcase
            end
        end
    end

    assign single_nib = (job_reg.kind == JOB_INIT) && !grp_reg[2];
    assign final_nib  = single_nib || nib_reg;
    assign nib_bits   = nib_reg ? val[3:0] : val[7:4];
    assign base       = {nib_bits, job_reg.bl, 2'b00, job_reg.rs};

    always_comb
    begin
        st_next  = st_reg;
        job_next = job_reg;
        grp_next = grp_reg;
        nib_next = nib_reg;
        wr_next  = wr_reg;
        q_pop    = 1'b0;
        emit     = 1'b0;
        i_pause  = 1'b0;
        i_byte   = 8'd0;
        i_us     = 16'd0;
        i_last   = 1'b0;
        case (st_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    job_next = q_job;
                    grp_next = 3'd0;
                    nib_next = 1'b0;
                    wr_next  = WR_SETUP;
                    case (q_job.kind)
                        JOB_INIT: st_next = BK_LEAD;
                        JOB_RAW:  st_next = BK_SINGLE;
                        default:  st_next = BK_WRITE;
                    endcase
                end
            end
            BK_LEAD:
            begin
                emit    = 1'b1;
                i_pause = 1'b1;
                i_us    = PAUSE_POWER_UP;
                if (advance)
                begin
                    st_next = BK_WRITE;
                end
            end
            BK_WRITE:
            begin
                emit = 1'b1;
                case (wr_reg)
                    WR_PULSE:
                    begin
                        i_byte = base | (8'd1 << EN_POS);
                        i_us   = PAUSE_EN_HIGH;
                    end
                    WR_HOLD:
                    begin
                        i_byte = base;
                        i_us   = PAUSE_EN_LOW;
                    end
                    default:
                    begin
                        i_byte = base;
                        i_us   = 16'd0;
                    end
                endcase
                i_last = (job_reg.kind != JOB_INIT) && final_nib && (wr_reg == WR_HOLD);
                if (advance)
                begin
                    if (wr_reg != WR_HOLD)
                    begin
                        wr_next = wr_reg + 2'd1;
                    end
                    else
                    begin
                        wr_next = WR_SETUP;
                        if (!final_nib)
                        begin
                            nib_next = 1'b1;
                        end
                        else
                        begin
                            nib_next = 1'b0;
                            st_next  = (job_reg.kind == JOB_INIT) ? BK_GAP : BK_IDLE;
                        end
                    end
                end
            end
            BK_GAP:
            begin
                emit    = 1'b1;
                i_pause = 1'b1;
                i_us    = PAUSE_INIT;
                i_last  = (grp_reg == GRP_LAST);
                if (advance)
                begin
                    if (grp_reg == GRP_LAST)
                    begin
                        st_next = BK_IDLE;
                    end
                    else
                    begin
                        grp_next = grp_reg + 3'd1;
                        st_next  = BK_WRITE;
                    end
                end
            end
            BK_SINGLE:
            begin
                emit   = 1'b1;
                i_byte = {7'd0, job_reg.bl} << BL_POS;
                i_last = 1'b1;
                if (advance)
                begin
                    st_next = BK_IDLE;
                end
            end
            default: st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= BK_IDLE;
            grp_reg       <= 3'd0;
            nib_reg       <= 1'b0;
            wr_reg        <= WR_SETUP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            grp_reg <= grp_next;
            nib_reg <= nib_next;
            wr_reg  <= wr_next;
            if (emit && advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (item.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (emit && advance)
        begin
            out_pause_reg <= i_pause;
            out_byte_reg  <= i_byte;
            out_us_reg    <= i_us;
            out_addr_reg  <= i_pause ? 7'd0 : bus_address;
            out_last_reg  <= i_last;
        end
    end

    assign item.valid          = out_valid_reg;
    assign item.is_pause       = out_pause_reg;
    assign item.bus_byte       = out_byte_reg;
    assign item.pause_us       = out_us_reg;
    assign item.target_address = out_addr_reg;
    assign item.last           = out_last_reg;

endmodule

[hw/rtl/char_lcd_nibble_sequencer.sv]
// The first result of a command passes through the queue, the sequencer state
// register and the output register. Throughput: one result per cycle while
// item.ready holds; a command holds the expander sequencer for 1 result (backlight),
// 6 (byte, set cursor) or 45 (init); the queue holds QUEUE_DEPTH commands meanwhile.
// Reset: sequencer idle, queue empty, display bits and backlight cleared,
// line_count = 2, bus_address = 0.
module char_lcd_nibble_sequencer
    import clns_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    clns_cmd_if.sink    cmd,
    clns_item_if.source item
);

    logic [1:0] line_count_reg;
    logic [6:0] bus_address_reg;
    logic       q_full;
    logic       q_push;
    job_t       q_push_job;
    logic       q_pop;
    logic       q_valid;
    job_t       q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg  <= 2'd2;
            bus_address_reg <= 7'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LINE_COUNT:  line_count_reg  <= cfg_data[1:0];
                CFG_BUS_ADDRESS: bus_address_reg <= cfg_data;
                default:         line_count_reg  <= line_count_reg;
            endcase
        end
    end

    clns_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .line_count (line_count_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (q_push_job)
    );

    clns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_head)
    );

    clns_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_job       (q_head),
        .q_pop       (q_pop),
        .bus_address (bus_address_reg),
        .item        (item)
    );

endmodule

[hw/rtl/clns_checker.sv]
`include "char_lcd_nibble_sequencer_macros.svh"

module clns_checker
    import clns_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic        item_is_pause,
    input logic [7:0]  item_bus_byte,
    input logic [15:0] item_pause_us,
    input logic [6:0]  item_target_address,
    input logic        item_last
);

    `CLNS_ASSERT_NEXT(a_hold_valid, item_valid && !item_ready, item_valid)
    `CLNS_ASSERT_NOW(a_pause_blank, item_valid && item_is_pause, item_bus_byte == 8'd0 && item_target_address == 7'd0)
    `CLNS_ASSERT_NOW(a_pulse_wait, item_valid && !item_is_pause && item_bus_byte[EN_POS], item_pause_us == PAUSE_EN_HIGH && !item_last)
    `CLNS_ASSERT_NOW(a_pause_len, item_valid && item_is_pause, item_pause_us == PAUSE_POWER_UP || item_pause_us == PAUSE_INIT)

endmodule

bind char_lcd_nibble_sequencer clns_checker u_clns_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .item_valid          (item.valid),
    .item_ready          (item.ready),
    .item_is_pause       (item.is_pause),
    .item_bus_byte       (item.bus_byte),
    .item_pause_us       (item.pause_us),
    .item_target_address (item.target_address),
    .item_last           (item.last)
);
